[hw/rtl/hzbcd_pkg.sv]
// Package for the hertz to packed BCD converter.
// Field types, reciprocal constants for the fixed divisions and the stage advance struct.
// No dependencies.
`default_nettype none

package hzbcd_pkg;

  localparam int unsigned FreqW  = 30;
  localparam int unsigned UnitsW = 27;
  localparam int unsigned QuadW  = 14;
  localparam int unsigned PairW  = 7;
  localparam int unsigned ByteW  = 8;

  typedef logic [FreqW-1:0]  freq_hz_t;
  typedef logic [UnitsW-1:0] units_t;
  typedef logic [QuadW-1:0]  quad_t;
  typedef logic [PairW-1:0]  pair_t;
  typedef logic [ByteW-1:0]  bcd_byte_t;

  // x / 10 = (x * Div10Mul) >> Div10Shift, exact for x < 2^30
  localparam logic [30:0] Div10Mul   = 31'd1717986919;
  localparam int unsigned Div10Shift = 34;

  // x / 10000 = (x * Div1e4Mul) >> Div1e4Shift, exact for x <= MaxUnits
  localparam units_t      Div1e4Mul   = 27'd109951163;
  localparam int unsigned Div1e4Shift = 40;

  // x / 100 = (x * Div100Mul) >> Div100Shift, exact for x <= 9999
  localparam quad_t       Div100Mul   = 14'd10486;
  localparam int unsigned Div100Shift = 20;

  // x / 10 = (x * DivTenMul) >> DivTenShift, exact for x <= 99
  localparam pair_t       DivTenMul   = 7'd103;
  localparam int unsigned DivTenShift = 10;

  localparam units_t MaxUnits  = 27'd99999999;
  localparam units_t QuadBase  = 27'd10000;
  localparam quad_t  PairBase  = 14'd100;
  localparam pair_t  DigitBase = 7'd10;
  localparam logic [3:0] MaxDigit = 4'd9;

  typedef struct packed {
    logic div;
    logic rem;
    logic pack;
  } hzbcd_adv_t;

endpackage

`default_nettype wire

[hw/rtl/hzbcd_if.sv]
// Valid/ready channel interfaces for the hertz to packed BCD converter.
// Depends on hzbcd_pkg.
`default_nettype none

interface hzbcd_in_if import hzbcd_pkg::*; ();
  logic     valid;
  logic     ready;
  freq_hz_t freq_hz;

  modport source (output valid, output freq_hz, input ready);
  modport sink   (input valid, input freq_hz, output ready);
endinterface

interface hzbcd_out_if import hzbcd_pkg::*; ();
  logic      valid;
  logic      ready;
  bcd_byte_t bcd_byte0;
  bcd_byte_t bcd_byte1;
  bcd_byte_t bcd_byte2;
  bcd_byte_t bcd_byte3;

  modport source (output valid, output bcd_byte0, output bcd_byte1, output bcd_byte2,
                  output bcd_byte3, input ready);
  modport sink   (input valid, input bcd_byte0, input bcd_byte1, input bcd_byte2,
                  input bcd_byte3, output ready);
endinterface

`default_nettype wire

[hw/rtl/hzbcd_quad_split.sv]
// Splits a four digit value (0..9999) into two packed BCD bytes over three stages.
// Stage enables come from the top level. Depends on hzbcd_pkg.
`default_nettype none

module hzbcd_quad_split import hzbcd_pkg::*; (
  input  logic       clk_i,
  input  hzbcd_adv_t adv_i,
  input  quad_t      quad_i,
  output bcd_byte_t  hi_byte_o,
  output bcd_byte_t  lo_byte_o
);

  function automatic bcd_byte_t pack_pair(pair_t p);
    logic [2*PairW-1:0] t;
    logic [3:0]         tens;
    pair_t              ones;
    t    = (2*PairW)'(p) * (2*PairW)'(DivTenMul);
    tens = t[DivTenShift +: 4];
    ones = p - PairW'(tens) * DigitBase;
    return {tens, ones[3:0]};
  endfunction

  logic [2*QuadW-1:0] prod_div;
  pair_t              div_q_d;
  quad_t              rem_full;

  pair_t     div_q_q;
  quad_t     div_quad_q;
  pair_t     pair_hi_q, pair_lo_q;
  bcd_byte_t hi_byte_q, lo_byte_q;

  assign prod_div = (2*QuadW)'(quad_i) * (2*QuadW)'(Div100Mul);
  assign div_q_d  = prod_div[Div100Shift +: PairW];
  assign rem_full = div_quad_q - QuadW'(div_q_q) * PairBase;

  always_ff @(posedge clk_i) begin
    if (adv_i.div) begin
      div_q_q    <= div_q_d;
      div_quad_q <= quad_i;
    end
    if (adv_i.rem) begin
      pair_hi_q <= div_q_q;
      pair_lo_q <= rem_full[PairW-1:0];
    end
    if (adv_i.pack) begin
      hi_byte_q <= pack_pair(pair_hi_q);
      lo_byte_q <= pack_pair(pair_lo_q);
    end
  end

  assign hi_byte_o = hi_byte_q;
  assign lo_byte_o = lo_byte_q;

endmodule

`default_nettype wire

[hw/rtl/hz_to_packed_bcd_freq_top.sv]
// Top level of the hertz to packed BCD converter.
// Depends on hzbcd_pkg, hzbcd_if and hzbcd_quad_split.
`default_nettype none

// Takes a frequency in hertz, drops the units digit (divide by ten, truncating) and
// returns eight packed BCD digits, most significant pair in bcd_byte0. Inputs of
// 1e9 Hz or more saturate to all 0x99. One word is accepted every cycle unless a
// stalled output has backed up the stages; a result is offered after an input
// register, then one stage each for the reciprocal divisions by 10 and 10000, the
// back-multiply for the low four digits, the division by 100, the back-multiply for
// its remainder and the digit packing. Stages collapse bubbles, so a stalled output
// only holds back the words queued behind it. No state is kept between words.
module hz_to_packed_bcd_freq_top import hzbcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  hzbcd_in_if.sink    freq_i,
  hzbcd_out_if.source bcd_o
);

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0] valid_q, valid_d, adv;

  freq_hz_t            s1_hz_q;
  units_t              s2_units_q, s3_units_q;
  quad_t               s3_hi_q, s4_hi_q, s4_lo_q;
  logic [60:0]         prod10;
  units_t              units_raw, units_d;
  logic [2*UnitsW-1:0] prod1e4;
  quad_t               hi_d;
  units_t              lo_full;
  hzbcd_adv_t          adv_split;

  always_comb begin
    adv[NumStages-1] = ~valid_q[NumStages-1] | bcd_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = ~valid_q[k] | adv[k+1];
    end
  end

  always_comb begin
    valid_d[0] = adv[0] ? freq_i.valid : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign freq_i.ready = adv[0];

  // divide by ten, then clamp to eight digits
  assign prod10    = 61'(s1_hz_q) * 61'(Div10Mul);
  assign units_raw = prod10[Div10Shift +: UnitsW];
  assign units_d   = (units_raw > MaxUnits) ? MaxUnits : units_raw;

  assign prod1e4 = (2*UnitsW)'(s2_units_q) * (2*UnitsW)'(Div1e4Mul);
  assign hi_d    = prod1e4[Div1e4Shift +: QuadW];
  assign lo_full = s3_units_q - UnitsW'(s3_hi_q) * QuadBase;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_hz_q <= freq_i.freq_hz;
    end
    if (adv[1]) begin
      s2_units_q <= units_d;
    end
    if (adv[2]) begin
      s3_units_q <= s2_units_q;
      s3_hi_q    <= hi_d;
    end
    if (adv[3]) begin
      s4_hi_q <= s3_hi_q;
      s4_lo_q <= lo_full[QuadW-1:0];
    end
  end

  assign adv_split.div  = adv[4];
  assign adv_split.rem  = adv[5];
  assign adv_split.pack = adv[6];

  hzbcd_quad_split u_split_hi (
    .clk_i     (clk_i),
    .adv_i     (adv_split),
    .quad_i    (s4_hi_q),
    .hi_byte_o (bcd_o.bcd_byte0),
    .lo_byte_o (bcd_o.bcd_byte1)
  );

  hzbcd_quad_split u_split_lo (
    .clk_i     (clk_i),
    .adv_i     (adv_split),
    .quad_i    (s4_lo_q),
    .hi_byte_o (bcd_o.bcd_byte2),
    .lo_byte_o (bcd_o.bcd_byte3)
  );

  assign bcd_o.valid = valid_q[NumStages-1];

`ifndef NO_ASSERTIONS
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freq_i.valid && freq_i.ready |=> valid_q[0])
    else $error("accepted word not captured");

  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> s2_units_q <= MaxUnits)
    else $error("units above eight digits");

  a_quads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] |-> (s4_lo_q < QuadBase[QuadW-1:0]) && (s4_hi_q < QuadBase[QuadW-1:0]))
    else $error("four digit split out of range");

  a_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcd_o.valid |->
      (bcd_o.bcd_byte0[7:4] <= MaxDigit) && (bcd_o.bcd_byte0[3:0] <= MaxDigit) &&
      (bcd_o.bcd_byte1[7:4] <= MaxDigit) && (bcd_o.bcd_byte1[3:0] <= MaxDigit) &&
      (bcd_o.bcd_byte2[7:4] <= MaxDigit) && (bcd_o.bcd_byte2[3:0] <= MaxDigit) &&
      (bcd_o.bcd_byte3[7:4] <= MaxDigit) && (bcd_o.bcd_byte3[3:0] <= MaxDigit))
    else $error("non-BCD digit on output");
`endif

endmodule

`default_nettype wire

[test/hz_to_packed_bcd_freq_top_test.sv]
// Testbench for hz_to_packed_bcd_freq_top: random and corner frequencies are driven through
// bursty valid/ready traffic, and each BCD word is checked against a local predictor.
// Depends on hzbcd_pkg, hzbcd_if and the converter RTL.
`timescale 1ns / 1ps

module hz_to_packed_bcd_freq_top_test import hzbcd_pkg::*; ();

  localparam int unsigned RandWords = 1330;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned HoldStart = 400;
  localparam int unsigned HoldLen   = 150;

  typedef struct packed {
    bcd_byte_t b0;
    bcd_byte_t b1;
    bcd_byte_t b2;
    bcd_byte_t b3;
  } bcd_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hzbcd_in_if  freq_if ();
  hzbcd_out_if bcd_if ();

  hz_to_packed_bcd_freq_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .freq_i (freq_if),
    .bcd_o  (bcd_if)
  );

  freq_hz_t    hz_pending[$];
  bcd_word_t   bcd_expected[$];
  bit          word_taken;
  int unsigned words_out;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned pat_age;
  bit          held_off;
  logic [15:0] stall_pat;
  bcd_word_t   want;

  freq_hz_t corner_hz[] = '{
    30'd0, 30'd9, 30'd10, 30'd19, 30'd99, 30'd100, 30'd123456789, 30'd987654321,
    30'd99999999, 30'd100000000, 30'd500000000, 30'd555555555, 30'd999999989,
    30'd999999990, 30'd999999999, 30'd1000000000, 30'd1000000009, 30'd1000000010,
    30'd1073741823, 30'd536870912, 30'd357913941, 30'd715827882, 30'd909090909,
    30'd90909090
  };

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // divide by ten, saturate to eight digits, pack two digits per byte
  function automatic bcd_word_t hz_to_bcd(freq_hz_t hz);
    int unsigned tens;
    bcd_byte_t   pairs[4];
    bcd_word_t   w;
    tens = int'(hz) / 10;
    if (tens > 99999999) tens = 99999999;
    for (int k = 3; k >= 0; k--) begin
      pairs[k] = {4'((tens % 100) / 10), 4'(tens % 10)};
      tens = tens / 100;
    end
    w.b0 = pairs[0];
    w.b1 = pairs[1];
    w.b2 = pairs[2];
    w.b3 = pairs[3];
    return w;
  endfunction

  task automatic check_byte(input string field, input bcd_byte_t exp_b, input bcd_byte_t got_b);
    if (exp_b !== got_b) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_b, got_b);
      mismatches++;
    end
  endtask

  // sender: bursts of words with random gaps; valid holds until the word is taken
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      freq_if.valid <= 1'b0;
    end else if (!freq_if.valid || word_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        freq_if.valid <= 1'b0;
      end else if (hz_pending.size() != 0) begin
        freq_if.valid   <= 1'b1;
        freq_if.freq_hz <= hz_pending[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        freq_if.valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern, plus one long hold-off to back the pipe up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      bcd_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      bcd_if.ready <= 1'b0;
    end else if (!held_off && words_out >= HoldStart) begin
      held_off  = 1'b1;
      hold_left = HoldLen - 1;
      bcd_if.ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = 16'hFFFF;
          1: stall_pat = 16'($urandom);
          2: stall_pat = ~(16'h1 << $urandom_range(0, 15));
          default: stall_pat = 16'($urandom | $urandom);
        endcase
        pat_age = $urandom_range(32, 256);
      end
      pat_age--;
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      bcd_if.ready <= stall_pat[0];
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (bcd_if.valid && bcd_if.ready) begin
        words_out++;
        if (bcd_expected.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h %h %h %h", $time,
                   bcd_if.bcd_byte0, bcd_if.bcd_byte1, bcd_if.bcd_byte2, bcd_if.bcd_byte3);
          mismatches++;
        end else begin
          want = bcd_expected.pop_front();
          check_byte("bcd_byte0", want.b0, bcd_if.bcd_byte0);
          check_byte("bcd_byte1", want.b1, bcd_if.bcd_byte1);
          check_byte("bcd_byte2", want.b2, bcd_if.bcd_byte2);
          check_byte("bcd_byte3", want.b3, bcd_if.bcd_byte3);
        end
      end
      word_taken = freq_if.valid && freq_if.ready;
      if (word_taken) begin
        bcd_expected.push_back(hz_to_bcd(freq_if.freq_hz));
        void'(hz_pending.pop_front());
      end
      if (word_taken || (bcd_if.valid && bcd_if.ready)) begin
        idle_cycles = 0;
      end else if (hz_pending.size() != 0 || bcd_expected.size() != 0) begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t: no progress for %0d cycles", $time, idle_cycles);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned v;
    int unsigned p;
    longint      s;
    rst_ni          = 1'b0;
    freq_if.valid   = 1'b0;
    freq_if.freq_hz = '0;
    bcd_if.ready    = 1'b0;
    word_taken      = 1'b0;
    burst_left      = $urandom_range(1, 48);
    gap_left        = 0;
    hold_left       = 0;
    pat_age         = 0;
    held_off        = 1'b0;
    stall_pat       = 16'hFFFF;

    foreach (corner_hz[i]) hz_pending.push_back(corner_hz[i]);
    for (int n = 0; n < RandWords; n++) begin
      case ($urandom_range(0, 19))
        0, 1: v = $urandom_range(1000000000, 1073741823);
        2, 3, 4: begin
          v = 0;
          for (int d = 0; d < 9; d++) begin
            case ($urandom_range(0, 2))
              0: v = v * 10;
              1: v = v * 10 + 9;
              default: v = v * 10 + $urandom_range(0, 9);
            endcase
          end
        end
        5, 6, 7: begin
          p = 1;
          repeat ($urandom_range(1, 9)) p = p * 10;
          s = longint'(p) * $urandom_range(1, 9) + $urandom_range(0, 20) - 10;
          if (s < 0) s = 0;
          if (s > 1073741823) s = 1073741823;
          v = int'(s);
        end
        8: v = $urandom_range(0, 999);
        default: v = $urandom_range(0, 999999999);
      endcase
      hz_pending.push_back(freq_hz_t'(v));
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (hz_pending.size() != 0 || bcd_expected.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
